@@ src/iiel_pkg.sv @@
// ---------------------------------------------------------------------------
// iiel_pkg: shared types and constants for the indexed insert/erase list
// Request kinds, status codes, cell operations and default sizes.
// ---------------------------------------------------------------------------
package iiel_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // field widths of the request and response words
    localparam int KIND_W  = 3;
    localparam int POS_W   = 5;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    typedef enum logic [KIND_W-1:0] {
        K_APPEND = 3'd0,
        K_INSERT = 3'd1,
        K_ERASE  = 3'd2,
        K_REMOVE = 3'd3,
        K_QUERY  = 3'd4
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE   = 2'd0,
        ST_BOUNDS = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    // what every cell of the chain does in one step
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_ERASE
    } t_op;

endpackage

@@ src/iiel_req_if.sv @@
// ---------------------------------------------------------------------------
// iiel_req_if: request channel
// Valid/ready channel carrying one request word.
// ---------------------------------------------------------------------------
interface iiel_req_if;
    logic                      valid;
    logic                      ready;
    logic [iiel_pkg::KIND_W-1:0] kind;
    logic [iiel_pkg::POS_W-1:0]  position;
    logic [iiel_pkg::VAL_W-1:0]  element_value;

    modport source (output valid, output kind, output position, output element_value,
                    input ready);
    modport sink   (input valid, input kind, input position, input element_value,
                    output ready);
endinterface

@@ src/iiel_rsp_if.sv @@
// ---------------------------------------------------------------------------
// iiel_rsp_if: response channel
// Valid/ready channel carrying one result word.
// ---------------------------------------------------------------------------
interface iiel_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [iiel_pkg::STAT_W-1:0]  status;
    logic [iiel_pkg::COUNT_W-1:0] entry_count;
    logic [iiel_pkg::VAL_W-1:0]   front_value;
    logic [iiel_pkg::VAL_W-1:0]   back_value;
    logic                         not_empty;

    modport source (output valid, output status, output entry_count, output front_value,
                    output back_value, output not_empty, input ready);
    modport sink   (input valid, input status, input entry_count, input front_value,
                    input back_value, input not_empty, output ready);
endinterface

@@ src/iiel_cell.sv @@
// ---------------------------------------------------------------------------
// iiel_cell: one entry of the list
// Holds, loads, takes its left neighbour (insert) or its right neighbour
// (erase), and offers its entry as the back tap when it is the last one.
// ---------------------------------------------------------------------------
module iiel_cell #(
    parameter int IDX   = 0,
    parameter int DW    = 32,
    parameter int CW    = 5,
    parameter int CMP_W = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  iiel_pkg::t_op        i_op,
    input  logic [CMP_W-1:0]     i_pos,
    input  logic [DW-1:0]        i_val,
    input  logic [DW-1:0]        i_left,
    input  logic [DW-1:0]        i_right,
    input  logic [CW-1:0]        i_cnt,
    output logic [DW-1:0]        o_data,
    output logic [DW-1:0]        o_tap
);
    import iiel_pkg::*;

    localparam logic [CMP_W-1:0] MY_IDX  = CMP_W'(IDX);
    localparam logic [CW-1:0]    LAST_AT = CW'(IDX + 1);

    logic [DW-1:0] r_data;
    logic [DW-1:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_op)
            OP_INSERT: begin
                if (MY_IDX > i_pos) begin
                    n_data = i_left;
                end else if (MY_IDX == i_pos) begin
                    n_data = i_val;
                end
            end
            OP_ERASE: begin
                // cells past the end are zero, so the vacated cell fills with zero
                if (MY_IDX >= i_pos) begin
                    n_data = i_right;
                end
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;
    assign o_tap  = (i_cnt == LAST_AT) ? r_data : '0;

endmodule

@@ src/indexed_insert_erase_list.sv @@
// ---------------------------------------------------------------------------
// indexed_insert_erase_list: bounded ordered list with insert and erase
// A chain of DEPTH cells that shifts up or down in one step.
// ---------------------------------------------------------------------------
// For each request, every cell of the chain moves at once in the cycle
// it is accepted (insert shifts up from the target, erase shifts down into
// it); the result word is then formed from the updated chain into the
// output register, and the back entry comes from an AND-OR over the cell
// taps. Forming the word waits while the output register still holds an
// untaken word, and no new request is taken until the word is formed.
// Reset clears every cell and the count.
module indexed_insert_erase_list #(
    parameter int DEPTH      = iiel_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = iiel_pkg::DATA_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    iiel_req_if.sink    i_req,
    iiel_rsp_if.source  o_rsp
);
    import iiel_pkg::*;

    localparam int CW    = $clog2(DEPTH + 1);
    localparam int CMP_W = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    logic            r_busy;
    t_status         r_status;
    t_status         n_status;
    logic            r_ov;
    logic            w_acc;
    logic            w_fin;
    t_op             w_op;
    t_op             w_cell_op;
    logic [CMP_W-1:0] w_pos;
    logic [CMP_W-1:0] w_req_pos;
    logic [CMP_W-1:0] w_cnt_ext;
    logic [DATA_WIDTH-1:0] w_val;
    logic [DATA_WIDTH-1:0] w_data [DEPTH];
    logic [DATA_WIDTH-1:0] w_tap  [DEPTH];
    logic [DATA_WIDTH-1:0] w_back;

    assign i_req.ready = !r_busy;
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_fin       = r_busy && (!r_ov || o_rsp.ready);

    assign w_req_pos = CMP_W'(i_req.position);
    assign w_cnt_ext = CMP_W'(r_count);
    assign w_val     = DATA_WIDTH'(i_req.element_value);

    // decode request against the current count
    always_comb begin
        w_op     = OP_HOLD;
        w_pos    = w_req_pos;
        n_status = ST_DONE;
        case (t_kind'(i_req.kind))
            K_APPEND: begin
                if (r_count >= FULL_CNT) begin
                    n_status = ST_FULL;
                end else begin
                    w_op  = OP_INSERT;
                    w_pos = w_cnt_ext;
                end
            end
            K_INSERT: begin
                if (w_req_pos > w_cnt_ext) begin
                    n_status = ST_BOUNDS;
                end else if (r_count >= FULL_CNT) begin
                    n_status = ST_FULL;
                end else begin
                    w_op = OP_INSERT;
                end
            end
            K_ERASE: begin
                if (w_req_pos >= w_cnt_ext) begin
                    n_status = ST_BOUNDS;
                end else begin
                    w_op = OP_ERASE;
                end
            end
            K_REMOVE: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_op  = OP_ERASE;
                    w_pos = w_cnt_ext - CMP_W'(1);
                end
            end
            default: begin
                w_op = OP_HOLD;
            end
        endcase
    end

    assign w_cell_op = w_acc ? w_op : OP_HOLD;

    always_comb begin
        case (w_cell_op)
            OP_INSERT: n_count = r_count + CW'(1);
            OP_ERASE:  n_count = r_count - CW'(1);
            default:   n_count = r_count;
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [DATA_WIDTH-1:0] w_left;
            logic [DATA_WIDTH-1:0] w_right;
            if (g == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_mid_l
                assign w_left = w_data[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign w_right = '0;
            end else begin : g_mid_r
                assign w_right = w_data[g+1];
            end
            iiel_cell #(
                .IDX   (g),
                .DW    (DATA_WIDTH),
                .CW    (CW),
                .CMP_W (CMP_W)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_op    (w_cell_op),
                .i_pos   (w_pos),
                .i_val   (w_val),
                .i_left  (w_left),
                .i_right (w_right),
                .i_cnt   (r_count),
                .o_data  (w_data[g]),
                .o_tap   (w_tap[g])
            );
        end
    endgenerate

    // only the last occupied cell drives its tap
    always_comb begin
        w_back = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_back = w_back | w_tap[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_busy  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_acc) begin
                r_busy <= 1'b1;
            end else if (w_fin) begin
                r_busy <= 1'b0;
            end
            if (w_fin) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_status <= n_status;
        end
    end

    // result word; empty cells hold zero so front and back read zero when empty
    logic [STAT_W-1:0]  r_o_status;
    logic [COUNT_W-1:0] r_o_count;
    logic [VAL_W-1:0]   r_o_front;
    logic [VAL_W-1:0]   r_o_back;
    logic               r_o_nempty;

    always_ff @(posedge i_clk) begin
        if (w_fin) begin
            r_o_status <= r_status;
            r_o_count  <= COUNT_W'(r_count);
            r_o_front  <= VAL_W'(w_data[0]);
            r_o_back   <= VAL_W'(w_back);
            r_o_nempty <= (r_count != '0);
        end
    end

    assign o_rsp.valid       = r_ov;
    assign o_rsp.status      = r_o_status;
    assign o_rsp.entry_count = r_o_count;
    assign o_rsp.front_value = r_o_front;
    assign o_rsp.back_value  = r_o_back;
    assign o_rsp.not_empty   = r_o_nempty;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count above depth");

    a_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r_busy)
        else $error("accepted request not in progress");

    a_word_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> $past(r_busy))
        else $error("result word without a request in progress");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(w_acc) |-> $stable(r_count))
        else $error("count moved without a request");

endmodule
